FILE: design/wind_and_visibility_slew_limiter_unit_assert.svh
// ----------------------------------------------------------------------------
// wind and visibility slew limiter assertion macros
// concurrent checks sampled on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef WIND_AND_VISIBILITY_SLEW_LIMITER_UNIT_ASSERT_SVH
`define WIND_AND_VISIBILITY_SLEW_LIMITER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define WVSL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define WVSL_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define WVSL_ASSERT(lbl, prop, msg)
`define WVSL_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

FILE: design/wvsl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wvsl_pkg
// types and constants shared by the wind and visibility slew limiter
// ----------------------------------------------------------------------------
package wvsl_pkg;

  localparam int unsigned VisMaxDef   = 1048575;
  localparam int unsigned VisResetVal = 20000;
  localparam int unsigned WindRateRst = 1024;
  localparam int unsigned VisRateRst  = 10000;

  // apb register file
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;
  localparam int unsigned IdxW  = 3;

  localparam logic [IdxW-1:0] RegTgtWindX = 3'd0;
  localparam logic [IdxW-1:0] RegTgtWindY = 3'd1;
  localparam logic [IdxW-1:0] RegTgtWindZ = 3'd2;
  localparam logic [IdxW-1:0] RegTgtVis   = 3'd3;
  localparam logic [IdxW-1:0] RegWindRate = 3'd4;
  localparam logic [IdxW-1:0] RegVisRate  = 3'd5;

  // shared arithmetic unit
  localparam int unsigned MulAW = 20;
  localparam int unsigned MulBW = 17;
  localparam int unsigned ProdW = MulAW + MulBW;
  localparam int unsigned SubW  = 20;

  typedef struct packed {
    logic        req_type;
    logic [15:0] dt;
  } in_t;

  typedef struct packed {
    logic signed [15:0] wind_x;
    logic signed [15:0] wind_y;
    logic signed [15:0] wind_z;
    logic        [19:0] visibility;
    logic               wind_settled;
    logic               vis_settled;
  } out_t;

  typedef struct packed {
    logic signed [15:0] tgt_wind_x;
    logic signed [15:0] tgt_wind_y;
    logic signed [15:0] tgt_wind_z;
    logic        [19:0] tgt_vis;
    logic        [15:0] wind_rate;
    logic        [19:0] vis_rate;
  } cfg_t;

  typedef struct packed {
    logic [MulAW-1:0] mul_a;
    logic [MulBW-1:0] mul_b;
    logic [SubW-1:0]  sub_a;
    logic [SubW-1:0]  sub_b;
  } alu_req_t;

  typedef struct packed {
    logic [ProdW-1:0] prod;
    logic [SubW-1:0]  diff;
    logic             ge;
  } alu_rsp_t;

endpackage
`default_nettype wire

FILE: design/wind_and_visibility_slew_limiter_unit.sv
// ----------------------------------------------------------------------------
// wind_and_visibility_slew_limiter_unit
// a snap request loads the targets and goes straight to the output state; a tick
// finishes early when the wind is at its target or less than one step from it,
// else it runs a 17-step square root and three 17-step divisions through one shared multiply/compare-subtract unit
// throughput: one request at a time; the next is taken while a result waits
// reset: async active low; control and config registers to defaults, no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module wind_and_visibility_slew_limiter_unit #(
  parameter int unsigned VisMax = wvsl_pkg::VisMaxDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  wvsl_pkg::in_t              in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output wvsl_pkg::out_t             out_data_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wvsl_pkg::AddrW-1:0] paddr,
  input  logic [wvsl_pkg::DataW-1:0] pwdata,
  output logic [wvsl_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import wvsl_pkg::*;

  cfg_t     cfg;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  assign pready = 1'b1;

  wvsl_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  wvsl_seq #(
    .VisMax (VisMax)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .alu_req_o   (alu_req),
    .alu_rsp_i   (alu_rsp)
  );

  wvsl_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

endmodule
`default_nettype wire

FILE: design/wvsl_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wvsl_alu
// shared unsigned multiplier and compare-subtract used by the sequencer
// ----------------------------------------------------------------------------
module wvsl_alu (
  input  wvsl_pkg::alu_req_t req_i,
  output wvsl_pkg::alu_rsp_t rsp_o
);
  import wvsl_pkg::*;

  logic [SubW:0] sub_full;

  always_comb begin
    rsp_o.prod = ProdW'(req_i.mul_a) * ProdW'(req_i.mul_b);
    sub_full   = {1'b0, req_i.sub_a} - {1'b0, req_i.sub_b};
    rsp_o.ge   = ~sub_full[SubW];
    rsp_o.diff = sub_full[SubW-1:0];
  end

endmodule
`default_nettype wire

FILE: design/wvsl_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wvsl_regs
// apb register file holding the targets and slew rates
// ----------------------------------------------------------------------------
module wvsl_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wvsl_pkg::AddrW-1:0] paddr,
  input  logic [wvsl_pkg::DataW-1:0] pwdata,
  output logic [wvsl_pkg::DataW-1:0] prdata,
  output wvsl_pkg::cfg_t             cfg_o
);
  import wvsl_pkg::*;

  cfg_t            cfg_q;
  logic            wr_en;
  logic [IdxW-1:0] idx;

  assign idx   = paddr[AddrW-1:2];
  assign wr_en = psel & penable & pwrite;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tgt_wind_x <= '0;
      cfg_q.tgt_wind_y <= '0;
      cfg_q.tgt_wind_z <= '0;
      cfg_q.tgt_vis    <= 20'(VisResetVal);
      cfg_q.wind_rate  <= 16'(WindRateRst);
      cfg_q.vis_rate   <= 20'(VisRateRst);
    end else if (wr_en) begin
      case (idx)
        RegTgtWindX: cfg_q.tgt_wind_x <= pwdata[15:0];
        RegTgtWindY: cfg_q.tgt_wind_y <= pwdata[15:0];
        RegTgtWindZ: cfg_q.tgt_wind_z <= pwdata[15:0];
        RegTgtVis:   cfg_q.tgt_vis    <= pwdata[19:0];
        RegWindRate: cfg_q.wind_rate  <= pwdata[15:0];
        RegVisRate:  cfg_q.vis_rate   <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegTgtWindX: prdata = DataW'(cfg_q.tgt_wind_x);
      RegTgtWindY: prdata = DataW'(cfg_q.tgt_wind_y);
      RegTgtWindZ: prdata = DataW'(cfg_q.tgt_wind_z);
      RegTgtVis:   prdata = DataW'(cfg_q.tgt_vis);
      RegWindRate: prdata = DataW'(cfg_q.wind_rate);
      RegVisRate:  prdata = DataW'(cfg_q.vis_rate);
      default:     prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: design/wvsl_seq.sv
`timescale 1ns / 1ps
`default_nettype none
`include "wind_and_visibility_slew_limiter_unit_assert.svh"
// ----------------------------------------------------------------------------
// wvsl_seq
// sequencer and state: steps, squared length, square root and three
// divisions run one step a cycle through the shared arithmetic unit
// ----------------------------------------------------------------------------
module wvsl_seq #(
  parameter int unsigned VisMax = wvsl_pkg::VisMaxDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wvsl_pkg::cfg_t     cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  wvsl_pkg::in_t      in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output wvsl_pkg::out_t     out_data_o,
  output wvsl_pkg::alu_req_t alu_req_o,
  input  wvsl_pkg::alu_rsp_t alu_rsp_i
);
  import wvsl_pkg::*;

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SWStep = 4'd1;
  localparam logic [3:0] SVStep = 4'd2;
  localparam logic [3:0] SSqX   = 4'd3;
  localparam logic [3:0] SSqY   = 4'd4;
  localparam logic [3:0] SSqZ   = 4'd5;
  localparam logic [3:0] SSqS   = 4'd6;
  localparam logic [3:0] SSqrt  = 4'd7;
  localparam logic [3:0] SProd  = 4'd8;
  localparam logic [3:0] SDiv   = 4'd9;
  localparam logic [3:0] SApply = 4'd10;
  localparam logic [3:0] SOut   = 4'd11;

  localparam logic [4:0]  LastStep = 5'd16;
  localparam logic [1:0]  LastComp = 2'd2;
  localparam logic [19:0] VisMaxW  = 20'(VisMax);
  localparam logic [19:0] VisRstW  = (VisMax < VisResetVal) ? 20'(VisMax) : 20'(VisResetVal);

  logic [3:0]         state_q;
  logic [4:0]         cnt_q;
  logic [1:0]         comp_q;
  logic               out_valid_q;
  logic signed [15:0] cur_wind_q [3];
  logic [19:0]        cur_vis_q;

  logic [15:0] dt_q;
  logic [16:0] mag_q [3];
  logic        neg_q [3];
  logic [19:0] vmag_q;
  logic        vneg_q;
  logic [15:0] step_q;
  logic [19:0] vstep_q;
  logic [33:0] len2_q;
  logic [17:0] rem_q;
  logic [16:0] root_q;
  logic [16:0] dvd_q;
  out_t        out_q;

  logic signed [15:0] tgt_w [3];
  logic [16:0]        wd_diff [3];
  logic [16:0]        wd_mag [3];
  logic               wd_neg [3];
  logic [20:0]        vd_diff;
  logic [19:0]        vd_mag;
  logic [19:0]        vis_tgt;
  logic               d_zero;
  logic               near;
  logic               out_free;
  logic [17:0]        q_ext;
  logic [17:0]        apply_sum;
  logic               wind_eq;

  always_comb begin
    tgt_w[0] = cfg_i.tgt_wind_x;
    tgt_w[1] = cfg_i.tgt_wind_y;
    tgt_w[2] = cfg_i.tgt_wind_z;
    for (int i = 0; i < 3; i++) begin
      wd_diff[i] = {tgt_w[i][15], tgt_w[i]} - {cur_wind_q[i][15], cur_wind_q[i]};
      wd_neg[i]  = wd_diff[i][16];
      wd_mag[i]  = wd_neg[i] ? 17'(-wd_diff[i]) : wd_diff[i];
    end
    vis_tgt = (32'(cfg_i.tgt_vis) < VisMax) ? cfg_i.tgt_vis : VisMaxW;
    vd_diff = {1'b0, vis_tgt} - {1'b0, cur_vis_q};
    vd_mag  = vd_diff[20] ? 20'(-vd_diff) : vd_diff[19:0];
    d_zero  = (mag_q[0] == '0) && (mag_q[1] == '0) && (mag_q[2] == '0);
    // squared length against squared step
    near    = len2_q < {2'b00, alu_rsp_i.prod[31:0]};
    q_ext   = {1'b0, dvd_q};
    apply_sum = {{2{cur_wind_q[comp_q][15]}}, cur_wind_q[comp_q]}
              + (neg_q[comp_q] ? (~q_ext + 18'd1) : q_ext);
    wind_eq = (cur_wind_q[0] == tgt_w[0]) && (cur_wind_q[1] == tgt_w[1])
           && (cur_wind_q[2] == tgt_w[2]);
  end

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    alu_req_o = '0;
    case (state_q)
      SWStep: begin
        alu_req_o.mul_a = 20'(cfg_i.wind_rate);
        alu_req_o.mul_b = 17'(dt_q);
      end
      SVStep: begin
        alu_req_o.mul_a = cfg_i.vis_rate;
        alu_req_o.mul_b = 17'(dt_q);
      end
      SSqX: begin
        alu_req_o.mul_a = 20'(mag_q[0]);
        alu_req_o.mul_b = mag_q[0];
      end
      SSqY: begin
        alu_req_o.mul_a = 20'(mag_q[1]);
        alu_req_o.mul_b = mag_q[1];
      end
      SSqZ: begin
        alu_req_o.mul_a = 20'(mag_q[2]);
        alu_req_o.mul_b = mag_q[2];
      end
      SSqS: begin
        alu_req_o.mul_a = 20'(step_q);
        alu_req_o.mul_b = 17'(step_q);
      end
      SProd: begin
        alu_req_o.mul_a = 20'(mag_q[comp_q]);
        alu_req_o.mul_b = 17'(step_q);
      end
      SSqrt: begin
        // next bit pair of the radicand against root*4+1
        alu_req_o.sub_a = {rem_q, len2_q[33:32]};
        alu_req_o.sub_b = {1'b0, root_q, 2'b01};
      end
      SDiv: begin
        alu_req_o.sub_a = {2'b00, rem_q[16:0], dvd_q[16]};
        alu_req_o.sub_b = {3'b000, root_q};
      end
      default: ;
    endcase
  end

  // control and current values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      cnt_q       <= '0;
      comp_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        cur_wind_q[i] <= '0;
      end
      cur_vis_q   <= VisRstW;
    end else begin
      if (state_q == SOut && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        SIdle: begin
          if (in_valid_i) begin
            if (in_data_i.req_type) begin
              for (int i = 0; i < 3; i++) begin
                cur_wind_q[i] <= tgt_w[i];
              end
              cur_vis_q <= vis_tgt;
              state_q   <= SOut;
            end else begin
              state_q <= SWStep;
            end
          end
        end
        SWStep: state_q <= SVStep;
        SVStep: state_q <= SSqX;
        SSqX: begin
          if (vmag_q != '0) begin
            if (vmag_q < vstep_q) begin
              cur_vis_q <= vis_tgt;
            end else if (vneg_q) begin
              cur_vis_q <= cur_vis_q - vstep_q;
            end else begin
              cur_vis_q <= cur_vis_q + vstep_q;
            end
          end
          state_q <= SSqY;
        end
        SSqY: state_q <= SSqZ;
        SSqZ: state_q <= SSqS;
        SSqS: begin
          if (d_zero || near) begin
            for (int i = 0; i < 3; i++) begin
              cur_wind_q[i] <= tgt_w[i];
            end
            state_q <= SOut;
          end else begin
            cnt_q   <= LastStep;
            state_q <= SSqrt;
          end
        end
        SSqrt: begin
          if (cnt_q == '0) begin
            comp_q  <= '0;
            state_q <= SProd;
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        SProd: begin
          cnt_q   <= LastStep;
          state_q <= SDiv;
        end
        SDiv: begin
          if (cnt_q == '0) begin
            state_q <= SApply;
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        SApply: begin
          cur_wind_q[comp_q] <= apply_sum[15:0];
          if (comp_q == LastComp) begin
            state_q <= SOut;
          end else begin
            comp_q  <= comp_q + 2'd1;
            state_q <= SProd;
          end
        end
        SOut: begin
          if (out_free) begin
            state_q <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          dt_q <= in_data_i.dt;
          for (int i = 0; i < 3; i++) begin
            mag_q[i] <= wd_mag[i];
            neg_q[i] <= wd_neg[i];
          end
          vmag_q <= vd_mag;
          vneg_q <= vd_diff[20];
        end
      end
      SWStep: step_q  <= alu_rsp_i.prod[31:16];
      SVStep: vstep_q <= alu_rsp_i.prod[35:16];
      SSqX:   len2_q  <= alu_rsp_i.prod[33:0];
      SSqY:   len2_q  <= len2_q + alu_rsp_i.prod[33:0];
      SSqZ:   len2_q  <= len2_q + alu_rsp_i.prod[33:0];
      SSqS: begin
        rem_q  <= '0;
        root_q <= '0;
      end
      SSqrt: begin
        len2_q <= {len2_q[31:0], 2'b00};
        rem_q  <= alu_rsp_i.ge ? alu_rsp_i.diff[17:0] : alu_req_o.sub_a[17:0];
        root_q <= {root_q[15:0], alu_rsp_i.ge};
      end
      SProd: begin
        // quotient stays below 2^17, so the top bits start as the remainder
        rem_q <= {2'b00, alu_rsp_i.prod[32:17]};
        dvd_q <= alu_rsp_i.prod[16:0];
      end
      SDiv: begin
        rem_q <= alu_rsp_i.ge ? alu_rsp_i.diff[17:0] : alu_req_o.sub_a[17:0];
        dvd_q <= {dvd_q[15:0], alu_rsp_i.ge};
      end
      SOut: begin
        if (out_free) begin
          out_q.wind_x       <= cur_wind_q[0];
          out_q.wind_y       <= cur_wind_q[1];
          out_q.wind_z       <= cur_wind_q[2];
          out_q.visibility   <= cur_vis_q;
          out_q.wind_settled <= wind_eq;
          out_q.vis_settled  <= (cur_vis_q == vis_tgt);
        end
      end
      default: ;
    endcase
  end

  `WVSL_ASSERT(a_step_within_len, (state_q == SProd) |-> ({1'b0, step_q} <= root_q), "wind step above vector length")
  `WVSL_ASSERT(a_quot_within_mag, (state_q == SApply) |-> (dvd_q <= mag_q[comp_q]), "wind component passes its target")
  `WVSL_ASSERT(a_root_narrow, (state_q == SSqrt && cnt_q != 5'd0) |-> !root_q[16], "square root overflows")
  `WVSL_ASSERT(a_result_loaded, (state_q == SOut && out_free) |=> (out_valid_q && out_q.visibility == cur_vis_q), "result not taken from current state")
  `WVSL_ASSERT_NEVER(a_comp_range, comp_q == 2'd3, "component index out of range")

endmodule
`default_nettype wire
